FILE: design/iirdf1_pkg.sv
`default_nettype none

package iirdf1_pkg;

    // default build of the filter
    localparam int ORDER_DEF          = 3;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // register file layout, fixed by the register map
    localparam int COEF_BITS     = 18;
    localparam int NUM_REGS      = 7;
    localparam int REG_IDX_BITS  = 3;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_FF0     = 3'd0;
    // feedback gain k sits at REG_FB_BASE + k
    localparam logic [REG_IDX_BITS-1:0] REG_FB_BASE = 3'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_ACC,
        S_OUT
    } t_seq_state;

    // control from the sequencer to the shared mac
    typedef struct packed {
        logic issue;  // operands valid, multiply this cycle
        logic first;  // first product of a word, restart the sum
    } t_mac_ctl;

endpackage

`default_nettype wire

FILE: design/iir_direct_form_one_filter.sv
`default_nettype none

// channel   | dir | handshake                          | payload
// ----------+-----+------------------------------------+-----------------------------------
// s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata: sample_in
// m_axis    | out | o_m_axis_tvalid / i_m_axis_tready  | tdata: sample_out, tuser: clipped
// apb       | in  | psel, penable, pwrite, pready      | paddr, pwdata, prdata (gains)
//
// once a word is accepted it passes through the single multiplier at one tap per cycle,
// then a state drains the product register and a state rounds and saturates into the
// output register. an idle state follows, and a new word is taken only there, never while
// the last one is in flight. s_axis is not ready while a word is being worked on or while
// its result waits for the output register.
// synchronous active-low reset clears history and loads unity on the current-input gain, zero elsewhere.

module iir_direct_form_one_filter
    import iirdf1_pkg::*;
#(
    parameter int ORDER          = ORDER_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input words
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire [((SAMPLE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,  // sample_in
    // result words
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     o_m_axis_tdata,  // sample_out
    output logic [0:0]                           o_m_axis_tuser,  // clipped
    // gain registers
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [APB_ADDR_BITS-1:0]              paddr,
    input  wire [APB_DATA_BITS-1:0]              pwdata,
    output logic [APB_DATA_BITS-1:0]             prdata,
    output logic                                 pready
);

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int TAP_BITS  = $clog2(2*ORDER+1);
    localparam int HIDX_BITS = (ORDER > 1) ? $clog2(ORDER) : 1;
    // seven products of sample by gain plus the rounding term never overflow this
    localparam int ACC_BITS  = SAMPLE_BITS + COEF_BITS + 3;

    localparam logic signed [COEF_BITS-1:0] UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;
    localparam logic signed [ACC_BITS-1:0]  SMAX  = ACC_BITS'((1 << (SAMPLE_BITS-1)) - 1);
    localparam logic signed [ACC_BITS-1:0]  SMIN  = -SMAX - ACC_BITS'(1);

    // gain registers, in register-map order
    logic signed [COEF_BITS-1:0]   r_coef [NUM_REGS];

    // history and the word being worked on
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_past_in  [ORDER];
    logic signed [SAMPLE_BITS-1:0] r_past_out [ORDER];

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_clip;

    logic                          in_ready;
    logic                          in_fire;
    logic                          out_free;
    logic                          out_step;
    t_mac_ctl                      mac_ctl;
    logic [TAP_BITS-1:0]           tap;
    logic [TAP_BITS-1:0]           tap_m1;
    logic [HIDX_BITS-1:0]          hidx;
    logic [REG_IDX_BITS-1:0]       coef_idx;
    logic signed [SAMPLE_BITS-1:0] mac_sample;
    logic signed [COEF_BITS-1:0]   mac_coef;
    logic signed [ACC_BITS-1:0]    acc;
    logic signed [ACC_BITS-1:0]    acc_shr;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          y_clip;

    logic                          cfg_wr;
    logic [REG_IDX_BITS-1:0]       cfg_idx;

    // ------------------------------------------------------------------
    // apb register port, zero wait states
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // unity on the current-input gain, everything else zero
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coef[i] <= (i == int'(REG_FF0)) ? UNITY : '0;
            end
        end else if (cfg_wr && (cfg_idx < REG_IDX_BITS'(NUM_REGS))) begin
            // only the low gain bits are kept, as two's complement
            r_coef[cfg_idx] <= pwdata[COEF_BITS-1:0];
        end
    end

    // reads return the gain sign extended; addresses past the map read zero
    always_comb begin
        prdata = '0;
        if (cfg_idx < REG_IDX_BITS'(NUM_REGS)) begin
            prdata = APB_DATA_BITS'(r_coef[cfg_idx]);
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign o_s_axis_tready = in_ready;
    assign in_fire         = i_s_axis_tvalid && in_ready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    iirdf1_seq #(
        .ORDER (ORDER)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_mac_ctl  (mac_ctl),
        .o_out_step (out_step),
        .o_tap      (tap)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= i_s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // operand select: tap 0 is the new sample, then for k = 1..ORDER
    // an odd tap takes ff gain k with x[n-k], an even tap fb gain k with y[n-k]
    // ------------------------------------------------------------------
    assign tap_m1 = tap - TAP_BITS'(1);
    assign hidx   = HIDX_BITS'(tap_m1 >> 1);

    always_comb begin
        if (tap == '0) begin
            coef_idx   = REG_FF0;
            mac_sample = r_x;
        end else if (tap[0]) begin
            coef_idx   = REG_IDX_BITS'(hidx) + REG_IDX_BITS'(1);
            mac_sample = r_past_in[hidx];
        end else begin
            coef_idx   = REG_FB_BASE + REG_IDX_BITS'(hidx) + REG_IDX_BITS'(1);
            mac_sample = r_past_out[hidx];
        end
        mac_coef = r_coef[coef_idx];
    end

    iirdf1_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .ACC_BITS       (ACC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (mac_sample),
        .i_coef   (mac_coef),
        .o_acc    (acc)
    );

    // ------------------------------------------------------------------
    // round (half lsb already in the sum), floor shift, saturate
    // ------------------------------------------------------------------
    assign acc_shr = acc >>> COEF_FRAC_BITS;

    always_comb begin
        y_clip = 1'b0;
        y_sat  = SAMPLE_BITS'(acc_shr);
        if (acc_shr > SMAX) begin
            y_sat  = SAMPLE_BITS'(SMAX);
            y_clip = 1'b1;
        end else if (acc_shr < SMIN) begin
            y_sat  = SAMPLE_BITS'(SMIN);
            y_clip = 1'b1;
        end
    end

    // history shifts once per finished word; the saturated value is fed back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER; i++) begin
                r_past_in[i]  <= '0;
                r_past_out[i] <= '0;
            end
        end else if (out_step) begin
            for (int i = ORDER - 1; i > 0; i--) begin
                r_past_in[i]  <= r_past_in[i-1];
                r_past_out[i] <= r_past_out[i-1];
            end
            r_past_in[0]  <= r_x;
            r_past_out[0] <= y_sat;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_step) begin
            r_out_sample <= y_sat;
            r_out_clip   <= y_clip;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_BITS'($unsigned(r_out_sample));
    assign o_m_axis_tuser  = r_out_clip;

endmodule

`default_nettype wire

FILE: design/iirdf1_mac.sv
`default_nettype none

module iirdf1_mac
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int ACC_BITS       = SAMPLE_BITS_DEF + COEF_BITS + 3
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire t_mac_ctl              i_ctl,
    input  wire signed [SAMPLE_BITS-1:0] i_sample,
    input  wire signed [COEF_BITS-1:0]   i_coef,
    output logic signed [ACC_BITS-1:0]   o_acc
);

    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    // half an lsb of the result, so the final shift rounds
    localparam logic signed [ACC_BITS-1:0] RND = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

    logic signed [PROD_BITS-1:0] r_prod;
    logic                        r_prod_vld;
    logic                        r_prod_first;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld   <= 1'b0;
            r_prod_first <= 1'b0;
        end else begin
            r_prod_vld   <= i_ctl.issue;
            r_prod_first <= i_ctl.first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
    end

    always_comb begin
        n_acc = r_prod_first ? RND : r_acc;
        n_acc = n_acc + ACC_BITS'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (r_prod_vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

FILE: design/iirdf1_seq.sv
`default_nettype none

module iirdf1_seq
    import iirdf1_pkg::*;
#(
    parameter int ORDER = ORDER_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  wire                                 i_out_free,
    output logic                                o_in_ready,
    output t_mac_ctl                            o_mac_ctl,
    output logic                                o_out_step,
    output logic [$clog2(2*ORDER+1)-1:0]        o_tap
);

    localparam int TAP_BITS = $clog2(2*ORDER+1);
    localparam logic [TAP_BITS-1:0] TAP_LAST = TAP_BITS'(2*ORDER);

    t_seq_state           r_state;
    t_seq_state           n_state;
    logic [TAP_BITS-1:0]  r_tap;
    logic [TAP_BITS-1:0]  n_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        case (r_state)
            S_IDLE: begin
                n_tap = '0;
                if (i_in_valid) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_tap == TAP_LAST) begin
                    n_state = S_ACC;
                end else begin
                    n_tap = r_tap + TAP_BITS'(1);
                end
            end
            S_ACC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_mac_ctl.issue = 1'b0;
        o_mac_ctl.first = 1'b0;
        o_out_step      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_MAC: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_ctl.first = (r_tap == '0);
            end
            S_ACC: begin
            end
            S_OUT: begin
                o_out_step = i_out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_tap = r_tap;

endmodule

`default_nettype wire

FILE: tb/sv/iir_df1_checker.sv
module iir_df1_checker
    import iirdf1_pkg::*;
(
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_s_tvalid,
    input  wire                                      i_s_tready,
    input  wire [((SAMPLE_BITS_DEF+7)/8)*8-1:0]      i_s_tdata,  // sample_in
    input  wire                                      i_m_tvalid,
    input  wire                                      i_m_tready,
    input  wire [((SAMPLE_BITS_DEF+7)/8)*8-1:0]      i_m_tdata,  // sample_out
    input  wire [0:0]                                i_m_tuser,  // clipped
    input  wire                                      i_psel,
    input  wire                                      i_penable,
    input  wire                                      i_pwrite,
    input  wire                                      i_pready,
    input  wire [APB_ADDR_BITS-1:0]                  i_paddr,
    input  wire [APB_DATA_BITS-1:0]                  i_pwdata,
    output int                                       o_fail_count,
    output int                                       o_pending,
    output int                                       o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FB = COEF_FRAC_BITS_DEF;
    localparam int NO = ORDER_DEF;
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SB - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic          clipped;
        logic [SB-1:0] sample;
    } t_filt_word;

    logic signed [COEF_BITS-1:0] ff_gain [0:3];
    logic signed [COEF_BITS-1:0] fb_gain [1:3];
    logic signed [SB-1:0]        x_hist  [0:NO-1];
    logic signed [SB-1:0]        y_hist  [0:NO-1];

    t_filt_word filtered_q [$];
    t_filt_word want;
    logic [REG_IDX_BITS-1:0] reg_idx;
    int fail_cnt = 0;
    int check_cnt = 0;

    // one step of the fixed-point direct form one recursion, history shifts along
    function automatic t_filt_word filter_step(input logic signed [SB-1:0] x);
        longint acc;
        longint y;
        int k;
        t_filt_word w;
        acc = longint'(ff_gain[0]) * longint'(x);
        for (k = 1; k <= NO; k++) begin
            acc += longint'(ff_gain[k]) * longint'(x_hist[k-1]);
            acc += longint'(fb_gain[k]) * longint'(y_hist[k-1]);
        end
        // add half an lsb then floor
        acc += longint'(1) <<< (FB - 1);
        y = acc >>> FB;
        w.clipped = 1'b0;
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
            w.clipped = 1'b1;
        end
        if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
            w.clipped = 1'b1;
        end
        for (k = NO - 1; k > 0; k--) begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        y_hist[0] = y[SB-1:0];
        w.sample = y[SB-1:0];
        return w;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_cnt < REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NO; k++) begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
            ff_gain[0] = COEF_BITS'(1 << FB);
            for (int k = 1; k <= 3; k++) begin
                ff_gain[k] = '0;
                fb_gain[k] = '0;
            end
            filtered_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (filtered_q.size() == 0) begin
                    note_failure($sformatf("result word with none pending: sample %0d clipped %0b",
                                           $signed(i_m_tdata[SB-1:0]), i_m_tuser[0]));
                end else begin
                    want = filtered_q.pop_front();
                    check_cnt++;
                    if (want.sample !== i_m_tdata[SB-1:0] || want.clipped !== i_m_tuser[0]) begin
                        note_failure($sformatf(
                            "word %0d: sample exp %0d got %0d, clipped exp %0b got %0b",
                            check_cnt, $signed(want.sample), $signed(i_m_tdata[SB-1:0]),
                            want.clipped, i_m_tuser[0]));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                filtered_q.push_back(filter_step(i_s_tdata[SB-1:0]));
            end
            // only the low coefficient bits count, as two's complement
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_idx = i_paddr[REG_IDX_BITS+1:2];
                if (reg_idx <= REG_FB_BASE) begin
                    ff_gain[reg_idx - REG_FF0] = i_pwdata[COEF_BITS-1:0];
                end else if (reg_idx < NUM_REGS) begin
                    fb_gain[reg_idx - REG_FB_BASE] = i_pwdata[COEF_BITS-1:0];
                end
            end
        end
        o_pending    <= filtered_q.size();
        o_fail_count <= fail_cnt;
        o_checked    <= check_cnt;
    end

endmodule

FILE: tb/sv/tb.sv
module tb;
    import iirdf1_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int TDATA_W     = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int GAIN_ONE    = 1 << COEF_FRAC_BITS_DEF;
    localparam int GAIN_MAX    = (1 << (COEF_BITS - 1)) - 1;
    localparam int GAIN_MIN    = -(1 << (COEF_BITS - 1));
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_WORDS = 165;

    // index past the register map, writes there must be dropped
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 3'd7;

    typedef enum int {
        GAINS_MILD,     // small gains, output mostly in range
        GAINS_FULL,     // any 18 bit pattern
        GAINS_EXTREME,  // rails, zero and plus/minus unity
        GAINS_DIRECT    // feedforward only, no feedback
    } t_gain_style;

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_MASK
    } t_ready_mode;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // input word channel
    logic               s_tvalid = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;   // sample_in
    wire                s_tready;

    // result word channel
    wire                m_tvalid;
    logic               m_tready = 1'b0;
    wire  [TDATA_W-1:0] m_tdata;         // sample_out
    wire  [0:0]         m_tuser;         // clipped

    // gain register port
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    wire  [APB_DATA_BITS-1:0] prdata;
    wire                      pready;

    int fail_count;
    int pending;
    int checked;

    iir_direct_form_one_filter dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // watches both channels and the register port, predicts and compares
    iir_df1_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // gains for the next setting, feedforward taps 0..3 and feedback taps 1..3
    logic [COEF_BITS-1:0] ff_set [0:3];
    logic [COEF_BITS-1:0] fb_set [1:3];

    // sender burst shaping
    int unsigned burst_left = 1;
    bit          bursty     = 1'b1;
    int          words_sent = 0;
    int          settings   = 0;

    // receiver hold-off request, raised once by the stimulus
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt  = 0;

    // receiver stall pattern, its mode and mask are redrawn at random
    t_ready_mode ready_mode = RX_ALWAYS;
    logic [7:0]  ready_mask = 8'hff;
    int          ready_cyc  = 0;

    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            // long hold-off: the block fills and stalls its input
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
        end else begin
            if (ready_cyc % 64 == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                ready_mask = 8'($urandom());
            end
            case (ready_mode)
                RX_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                RX_HALF: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= ready_mask[ready_cyc % 8];
                end
            endcase
            ready_cyc++;
        end
    end

    // offer one word and wait for it to be taken; at the end of a burst in bursty mode
    // drop valid for a random gap, which may be empty; otherwise keep valid high for the next word
    task automatic send_sample(input logic [SB-1:0] s);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(s);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (bursty) begin
                gap = $urandom_range(0, 10);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // one register write: setup cycle then access cycle
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // write all seven gains, upper data bits carry junk that must be ignored
    task automatic load_gains();
        logic [APB_DATA_BITS-1:0] junk;
        int k;
        for (k = 0; k <= 3; k++) begin
            junk = $urandom();
            junk[COEF_BITS-1:0] = ff_set[k];
            write_reg(REG_FF0 + REG_IDX_BITS'(k), junk);
        end
        for (k = 1; k <= 3; k++) begin
            junk = $urandom();
            junk[COEF_BITS-1:0] = fb_set[k];
            write_reg(REG_FB_BASE + REG_IDX_BITS'(k), junk);
        end
        settings++;
    endtask

    task automatic set_gains(input int f0, input int f1, input int f2, input int f3,
                             input int b1, input int b2, input int b3);
        ff_set[0] = COEF_BITS'(f0);
        ff_set[1] = COEF_BITS'(f1);
        ff_set[2] = COEF_BITS'(f2);
        ff_set[3] = COEF_BITS'(f3);
        fb_set[1] = COEF_BITS'(b1);
        fb_set[2] = COEF_BITS'(b2);
        fb_set[3] = COEF_BITS'(b3);
        load_gains();
    endtask

    function automatic int pick_gain(input t_gain_style style, input bit is_fb);
        int v;
        case (style)
            GAINS_MILD: begin
                v = is_fb ? int'($urandom_range(0, 4095)) - 2048
                          : int'($urandom_range(0, 8191)) - 4096;
            end
            GAINS_FULL: begin
                v = $urandom();
            end
            GAINS_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       v = GAIN_MIN;
                    1:       v = GAIN_MAX;
                    2:       v = 0;
                    3:       v = GAIN_ONE;
                    default: v = -GAIN_ONE;
                endcase
            end
            default: begin
                v = is_fb ? 0 : $urandom();
            end
        endcase
        return v;
    endfunction

    // mostly full-range samples, some small ones, some rails
    function automatic logic [SB-1:0] pick_sample();
        logic [SB-1:0] s;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       s = 16'h7fff;
                    1:       s = 16'h8000;
                    2:       s = 16'h0000;
                    default: s = 16'hffff;
                endcase
            end
            1, 2: begin
                s = SB'(int'($urandom_range(0, 511)) - 256);
            end
            default: begin
                s = SB'($urandom());
            end
        endcase
        return s;
    endfunction

    // watchdog: ends the run when nothing moves for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("watchdog: no handshake for %0d cycles, %0d words pending", idle, pending);
        $display("iir_direct_form_one_filter: mismatch");
        $finish;
    end

    // stimulus
    initial begin
        int p;
        int n;
        t_gain_style style;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: unity pass-through, sample extremes and bit patterns
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'haaaa);

        // half gain: exact halves round toward plus infinity
        drain_results();
        set_gains(GAIN_ONE / 2, 0, 0, 0, 0, 0, 0);
        write_reg(REG_SPARE, $urandom());
        send_sample(16'h0001);
        send_sample(16'hffff);
        send_sample(16'h0003);
        send_sample(16'hfffd);

        // largest gain: both saturation rails
        drain_results();
        set_gains(GAIN_MAX, 0, 0, 0, 0, 0, 0);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h1000);

        // most negative gain: rails swap
        drain_results();
        set_gains(GAIN_MIN, 0, 0, 0, 0, 0, 0);
        send_sample(16'h7fff);
        send_sample(16'h8000);

        // feedback drives the output into saturation, clipped value fed back
        drain_results();
        set_gains(GAIN_ONE, GAIN_MAX, 0, GAIN_MIN, GAIN_ONE, -GAIN_ONE / 2, GAIN_MAX);
        send_sample(SB'(30000));
        send_sample(SB'(30000));
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);

        // random phases, a fresh gain setting each time
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            style = t_gain_style'(p % 4);
            for (n = 0; n <= 3; n++) ff_set[n] = COEF_BITS'(pick_gain(style, 1'b0));
            for (n = 1; n <= 3; n++) fb_set[n] = COEF_BITS'(pick_gain(style, 1'b1));
            load_gains();
            // one phase with the sender never idling
            bursty = (p != 3);
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (p == 2 && n == 40) hold_req <= 1'b1;
                // sender pauses mid-stream until every result is back
                if (p == 5 && n == 80) drain_results();
                send_sample(pick_sample());
            end
        end

        drain_results();
        repeat (24) @(posedge clk);

        $display("covered %0d input words over %0d gain settings, %0d results checked",
                 words_sent, settings, checked);
        $display("included rounding halves, both rails, feedback clipping, hold-off and drain");
        if (fail_count == 0 && pending == 0) begin
            $display("iir_direct_form_one_filter: match");
        end else begin
            $display("iir_direct_form_one_filter: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/iirdf1_pkg.sv
design/iirdf1_mac.sv
design/iirdf1_seq.sv
design/iir_direct_form_one_filter.sv
tb/sv/iir_df1_checker.sv
tb/sv/tb.sv
